FILE: hdl/lmsd_pkg.sv
// Shared types, constants and helper functions of the LED matrix scan driver.
`default_nettype none
package lmsd_pkg;

  localparam int unsigned MAX_COLUMNS = 64;
  localparam int unsigned MAX_ROWS    = 32;
  localparam int unsigned PWM_SLICES  = 16;

  localparam int unsigned COL_W    = $clog2(MAX_COLUMNS);
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);
  localparam int unsigned HALF_W   = ROW_W - 1;
  localparam int unsigned ADDR_W   = ROW_W + COL_W;
  localparam int unsigned MEM_DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned PWM_W    = $clog2(PWM_SLICES);
  localparam int unsigned CH_W     = 4;
  localparam int unsigned LVL_W    = 3 * CH_W;
  localparam int unsigned CCOUNT_W = 7;
  localparam int unsigned RCOUNT_W = 6;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b1;

  localparam logic [CCOUNT_W-1:0] COLUMN_COUNT_RST = CCOUNT_W'(MAX_COLUMNS);
  localparam logic [RCOUNT_W-1:0] ROW_COUNT_RST    = RCOUNT_W'(MAX_ROWS);

  typedef enum logic [2:0] {
    PH_CLK_HIGH = 3'd0,
    PH_CLK_LOW  = 3'd1,
    PH_BLANK    = 3'd2,
    PH_LATCH    = 3'd3,
    PH_UNLATCH  = 3'd4,
    PH_ADDRESS  = 3'd5,
    PH_ENABLE   = 3'd6
  } phase_e;

  // Effective panel size after clamping the configuration registers.
  typedef struct packed {
    logic [CCOUNT_W-1:0] cols;
    logic [RCOUNT_W-1:0] rows;
    logic [HALF_W:0]     halves;
  } cfg_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic              is_tick;
    logic [ADDR_W-1:0] addr;
    logic [LVL_W-1:0]  level;
  } entry_t;

  function automatic cfg_t eff_cfg(logic [CCOUNT_W-1:0] col_cnt,
                                   logic [RCOUNT_W-1:0] row_cnt);
    cfg_t c;
    logic [RCOUNT_W-1:0] r;
    c.cols = col_cnt;
    if (col_cnt == '0) c.cols = CCOUNT_W'(1);
    if (col_cnt > CCOUNT_W'(MAX_COLUMNS)) c.cols = CCOUNT_W'(MAX_COLUMNS);
    r = row_cnt;
    if (row_cnt < RCOUNT_W'(2)) r = RCOUNT_W'(2);
    if (row_cnt > RCOUNT_W'(MAX_ROWS)) r = RCOUNT_W'(MAX_ROWS);
    c.rows   = {r[RCOUNT_W-1:1], 1'b0};
    c.halves = (HALF_W+1)'(r >> 1);
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/lmsd_front.sv
// Front end: takes input words, drops out-of-range pixel writes, builds queue entries.
`default_nettype none
module lmsd_front (
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [lmsd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  wire logic                             s_axis_tuser,
  input  wire lmsd_pkg::cfg_t                   cfg_i,
  input  wire logic                             busy_i,
  input  wire logic                             q_full_i,
  output logic                                  q_push_o,
  output lmsd_pkg::entry_t                      q_entry_o
);

  logic [lmsd_pkg::COL_W-1:0] pix_col;
  logic [lmsd_pkg::ROW_W-1:0] pix_row;
  logic [7:0]                 red_val, green_val, blue_val;
  logic                       in_range;
  logic                       accept;

  assign pix_col   = s_axis_tdata[5:0];
  assign pix_row   = s_axis_tdata[10:6];
  assign red_val   = s_axis_tdata[18:11];
  assign green_val = s_axis_tdata[26:19];
  assign blue_val  = s_axis_tdata[34:27];

  assign in_range = ({1'b0, pix_col} < cfg_i.cols) && ({1'b0, pix_row} < cfg_i.rows);

  assign s_axis_tready = !q_full_i && !busy_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Ticks always go to the back; pixel writes only when they land on the panel.
  assign q_push_o          = accept && (s_axis_tuser || in_range);
  assign q_entry_o.is_tick = s_axis_tuser;
  assign q_entry_o.addr    = {pix_row, pix_col};
  assign q_entry_o.level   = {red_val[7:4], green_val[7:4], blue_val[7:4]};

endmodule
`default_nettype wire

FILE: hdl/lmsd_fifo.sv
// Short queue of classified entries between the front and the back.
`default_nettype none
module lmsd_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire lmsd_pkg::entry_t push_entry_i,
  input  wire logic             pop_i,
  output lmsd_pkg::entry_t      head_o,
  output logic                  empty_o,
  output logic                  full_o
);

  lmsd_pkg::entry_t                   slot_q [lmsd_pkg::FIFO_DEPTH];
  logic [lmsd_pkg::FIFO_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [lmsd_pkg::FIFO_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [lmsd_pkg::FIFO_PTR_W:0]      count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (lmsd_pkg::FIFO_PTR_W+1)'(lmsd_pkg::FIFO_DEPTH));
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lmsd_back.sv
// Back end: framebuffer memory, scan sequencer and registered pin word output.
`default_nettype none
module lmsd_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire lmsd_pkg::cfg_t                    cfg_i,
  input  wire lmsd_pkg::entry_t                  head_i,
  input  wire logic                              q_empty_i,
  output logic                                   q_pop_o,
  output logic                                   busy_o,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [lmsd_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tlast
);

  localparam int unsigned AW = lmsd_pkg::ADDR_W;
  localparam int unsigned CW = lmsd_pkg::COL_W;
  localparam int unsigned HW = lmsd_pkg::HALF_W;
  localparam int unsigned PW = lmsd_pkg::PWM_W;
  localparam int unsigned LW = lmsd_pkg::LVL_W;

  logic [LW-1:0] lvl_mem [lmsd_pkg::MEM_DEPTH];
  logic [LW-1:0] rd_top_q, rd_bot_q;

  logic          clr_q, clr_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  lmsd_pkg::phase_e phase_q, phase_d;
  logic [CW-1:0] col_q, col_d;
  logic [HW-1:0] hr_q, hr_d;
  logic [PW-1:0] slice_q, slice_d;
  logic [3:0]    held_row_q, held_row_d;
  logic          held_blank_q, held_blank_d;

  // Output stage.
  logic          ob_valid_q, ob_valid_d;
  logic          ob_color_q, ob_color_d;
  logic [PW-1:0] ob_slice_q, ob_slice_d;
  logic          ob_clk_q, ob_clk_d;
  logic          ob_latch_q, ob_latch_d;
  logic          ob_blank_q, ob_blank_d;
  logic [3:0]    ob_row_q, ob_row_d;
  logic          ob_done_q, ob_done_d;

  logic          advance;
  logic          pop_tick;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic [AW-1:0] rd_top_addr, rd_bot_addr;
  logic [CW-1:0] col_eff;
  logic [HW-1:0] hr_eff;
  logic [CW:0]   col_inc;
  logic [HW:0]   hr_inc;
  logic [HW:0]   bot_row;
  logic [5:0]    colors;

  assign busy_o   = clr_q;
  assign advance  = !ob_valid_q || m_axis_tready;
  assign q_pop_o  = !q_empty_i && !clr_q && advance;
  assign pop_tick = q_pop_o && head_i.is_tick;

  // Size may have shrunk since the last tick: counters past it restart at zero.
  assign col_eff = ({1'b0, col_q} >= cfg_i.cols) ? '0 : col_q;
  assign hr_eff  = ({1'b0, hr_q} >= cfg_i.halves) ? '0 : hr_q;
  assign col_inc = {1'b0, col_eff} + 1'b1;
  assign hr_inc  = {1'b0, hr_eff} + 1'b1;
  assign bot_row = {1'b0, hr_eff} + cfg_i.halves;

  assign rd_top_addr = {1'b0, hr_eff, col_eff};
  assign rd_bot_addr = {bot_row, col_eff};

  // Framebuffer writes come from the clearing pass or from a pixel entry.
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    mem_we    = 1'b0;
    mem_waddr = head_i.addr;
    mem_wdata = head_i.level;
    if (clr_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(lmsd_pkg::MEM_DEPTH - 1)) begin
        clr_d = 1'b0;
      end
    end else if (q_pop_o && !head_i.is_tick) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lvl_mem[mem_waddr] <= mem_wdata;
    end
    if (pop_tick) begin
      rd_top_q <= lvl_mem[rd_top_addr];
      rd_bot_q <= lvl_mem[rd_bot_addr];
    end
  end

  always_comb begin
    phase_d      = phase_q;
    col_d        = col_q;
    hr_d         = hr_q;
    slice_d      = slice_q;
    held_row_d   = held_row_q;
    held_blank_d = held_blank_q;
    ob_valid_d   = ob_valid_q;
    ob_color_d   = ob_color_q;
    ob_slice_d   = ob_slice_q;
    ob_clk_d     = ob_clk_q;
    ob_latch_d   = ob_latch_q;
    ob_blank_d   = ob_blank_q;
    ob_row_d     = ob_row_q;
    ob_done_d    = ob_done_q;

    if (ob_valid_q && m_axis_tready) begin
      ob_valid_d = 1'b0;
    end

    if (pop_tick) begin
      col_d      = col_eff;
      hr_d       = hr_eff;
      ob_valid_d = 1'b1;
      ob_color_d = 1'b0;
      ob_slice_d = slice_q;
      ob_clk_d   = 1'b0;
      ob_latch_d = 1'b0;
      ob_blank_d = held_blank_q;
      ob_row_d   = held_row_q;
      ob_done_d  = 1'b0;
      unique case (phase_q)
        lmsd_pkg::PH_CLK_HIGH: begin
          ob_color_d = 1'b1;
          ob_clk_d   = 1'b1;
          phase_d    = lmsd_pkg::PH_CLK_LOW;
        end
        lmsd_pkg::PH_CLK_LOW: begin
          ob_color_d = 1'b1;
          if (col_inc >= cfg_i.cols) begin
            col_d   = '0;
            phase_d = lmsd_pkg::PH_BLANK;
          end else begin
            col_d   = col_inc[CW-1:0];
            phase_d = lmsd_pkg::PH_CLK_HIGH;
          end
        end
        lmsd_pkg::PH_BLANK: begin
          ob_blank_d = 1'b1;
          phase_d    = lmsd_pkg::PH_LATCH;
        end
        lmsd_pkg::PH_LATCH: begin
          ob_latch_d   = 1'b1;
          ob_blank_d   = 1'b1;
          held_blank_d = 1'b1;
          phase_d      = lmsd_pkg::PH_UNLATCH;
        end
        lmsd_pkg::PH_UNLATCH: begin
          phase_d = lmsd_pkg::PH_ADDRESS;
        end
        lmsd_pkg::PH_ADDRESS: begin
          held_row_d = 4'(hr_eff);
          ob_row_d   = 4'(hr_eff);
          phase_d    = lmsd_pkg::PH_ENABLE;
        end
        default: begin
          held_blank_d = 1'b0;
          ob_blank_d   = 1'b0;
          phase_d      = lmsd_pkg::PH_CLK_HIGH;
          col_d        = '0;
          slice_d      = slice_q + 1'b1;
          if (slice_q == PW'(lmsd_pkg::PWM_SLICES - 1)) begin
            slice_d = '0;
            if (hr_inc >= cfg_i.halves) begin
              hr_d      = '0;
              ob_done_d = 1'b1;
            end else begin
              hr_d = hr_inc[HW-1:0];
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= 1'b1;
      clr_cnt_q    <= '0;
      phase_q      <= lmsd_pkg::PH_CLK_HIGH;
      col_q        <= '0;
      hr_q         <= '0;
      slice_q      <= '0;
      held_row_q   <= '0;
      held_blank_q <= 1'b1;
      ob_valid_q   <= 1'b0;
    end else begin
      clr_q        <= clr_d;
      clr_cnt_q    <= clr_cnt_d;
      phase_q      <= phase_d;
      col_q        <= col_d;
      hr_q         <= hr_d;
      slice_q      <= slice_d;
      held_row_q   <= held_row_d;
      held_blank_q <= held_blank_d;
      ob_valid_q   <= ob_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_color_q <= ob_color_d;
    ob_slice_q <= ob_slice_d;
    ob_clk_q   <= ob_clk_d;
    ob_latch_q <= ob_latch_d;
    ob_blank_q <= ob_blank_d;
    ob_row_q   <= ob_row_d;
    ob_done_q  <= ob_done_d;
  end

  // Colour bits: a level above the current slice lights the LED.
  assign colors[0] = ob_color_q && (rd_top_q[11:8] > ob_slice_q);
  assign colors[1] = ob_color_q && (rd_top_q[7:4]  > ob_slice_q);
  assign colors[2] = ob_color_q && (rd_top_q[3:0]  > ob_slice_q);
  assign colors[3] = ob_color_q && (rd_bot_q[11:8] > ob_slice_q);
  assign colors[4] = ob_color_q && (rd_bot_q[7:4]  > ob_slice_q);
  assign colors[5] = ob_color_q && (rd_bot_q[3:0]  > ob_slice_q);

  assign m_axis_tvalid = ob_valid_q;
  assign m_axis_tlast  = ob_done_q;
  assign m_axis_tdata  = {3'b000, colors, ob_row_q, ob_blank_q, ob_latch_q, ob_clk_q};

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !q_pop_o)
    else $error("queue popped during framebuffer clearing");

  a_latch_blanks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_tick && phase_q == lmsd_pkg::PH_LATCH) |=> held_blank_q)
    else $error("display not blanked after latch pulse");

  a_done_not_on_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ob_valid_q && ob_done_q) |-> (!ob_clk_q && !ob_latch_q && !ob_blank_q))
    else $error("frame end flagged on a word other than output enable");

  a_color_only_when_shifting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ob_valid_q && !ob_color_q) |-> (m_axis_tdata[12:7] == 6'b000000))
    else $error("colour data driven on a control word");

endmodule
`default_nettype wire

FILE: hdl/led_matrix_scan_driver_top.sv
// Top level of the LED matrix scan driver: configuration registers and part wiring.
//
//  Channel   Direction  Handshake             Contents
//  s_axis    in         tvalid/tready         pixel write (tuser=0) or scan tick (tuser=1)
//  m_axis    out        tvalid/tready         one panel pin word, tlast on the frame's last
//  cfg       in         cfg_we_i              column_count (index 0), row_count (index 1)
//
//  After reset all 2048 framebuffer entries are cleared; s_axis_tready stays low meanwhile.
//  Then, while the queue has room, one word is taken per cycle; a tick's pin word reaches m_axis
//  once it has waited in a queue slot and passed the framebuffer read and output register load.
//  The four-entry queue and the output register let input and output stall independently;
//  pixel writes produce no output word.
`default_nettype none
module led_matrix_scan_driver_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lmsd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lmsd_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pixel_column[5:0], pixel_row[10:6], red_value[18:11], green_value[26:19],
  // blue_value[34:27], zero fill [39:35]
  input  wire logic [lmsd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // op[0]
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // shift_clock[0], latch_strobe[1], blank_level[2], row_address[6:3], red_top[7],
  // green_top[8], blue_top[9], red_bottom[10], green_bottom[11], blue_bottom[12],
  // zero fill [15:13]
  output logic [lmsd_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // frame_done
  output logic                                  m_axis_tlast
);

  logic [lmsd_pkg::CCOUNT_W-1:0] column_count_q;
  logic [lmsd_pkg::RCOUNT_W-1:0] row_count_q;
  lmsd_pkg::cfg_t                cfg;
  lmsd_pkg::entry_t              push_entry, head;
  logic                          push, pop, q_empty, q_full, busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= lmsd_pkg::COLUMN_COUNT_RST;
      row_count_q    <= lmsd_pkg::ROW_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lmsd_pkg::CFG_COLUMN_COUNT: column_count_q <= cfg_wdata_i[lmsd_pkg::CCOUNT_W-1:0];
        lmsd_pkg::CFG_ROW_COUNT:    row_count_q    <= cfg_wdata_i[lmsd_pkg::RCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = lmsd_pkg::eff_cfg(column_count_q, row_count_q);

  lmsd_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_i         (cfg),
    .busy_i        (busy),
    .q_full_i      (q_full),
    .q_push_o      (push),
    .q_entry_o     (push_entry)
  );

  lmsd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (q_empty),
    .full_o       (q_full)
  );

  lmsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .head_i        (head),
    .q_empty_i     (q_empty),
    .q_pop_o       (pop),
    .busy_o        (busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

FILE: sim/tb_led_matrix_scan_driver_top.sv
// Self-checking testbench for the LED matrix scan driver top level.
`timescale 1ns / 1ps
module tb_led_matrix_scan_driver_top;

  localparam logic OP_SET_PIXEL = 1'b0;
  localparam logic OP_TICK      = 1'b1;
  localparam int   STUCK_LIMIT  = 10000;
  localparam int   SINK_HOLD    = 300;
  localparam int   SETTLE       = 10;
  localparam int   RUNS         = 9;

  typedef struct packed {
    logic       op;
    logic [5:0] col;
    logic [4:0] row;
    logic [7:0] red;
    logic [7:0] grn;
    logic [7:0] blu;
  } item_t;

  typedef struct packed {
    logic       sclk;
    logic       latch;
    logic       blank;
    logic [3:0] addr;
    logic       rt;
    logic       gt;
    logic       bt;
    logic       rb;
    logic       gb;
    logic       bb;
    logic       last;
  } pin_word_t;

  typedef struct packed {
    logic                           is_cfg;
    logic [lmsd_pkg::CFG_IDX_W-1:0] idx;
    logic [lmsd_pkg::CFG_W-1:0]     val;
    item_t                          it;
    logic                           typed;
    pin_word_t                      want;
  } step_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [lmsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [lmsd_pkg::CFG_W-1:0]      cfg_wdata_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [lmsd_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [lmsd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;

  // Mirror of the block: configuration, framebuffer and scan position.
  logic [6:0]       col_reg;
  logic [5:0]       row_reg;
  logic [11:0]      fb_level [lmsd_pkg::MAX_ROWS*lmsd_pkg::MAX_COLUMNS];
  int unsigned      sc_half;
  int unsigned      sc_slice;
  int unsigned      sc_col;
  lmsd_pkg::phase_e sc_phase;
  logic [3:0]       hold_addr;
  logic             hold_blank;

  pin_word_t     pin_words_due [$];
  step_t         dir_table [$];
  pin_word_t     got_want;
  int            mismatch_count;
  int            stuck_cycles;
  bit            sink_hold_req;
  bit            src_calm;

  int run_cols  [RUNS] = '{1, 2, 64, 1, 4, 127, 0, 3, 1};
  int run_rows  [RUNS] = '{2, 4, 32, 2, 7, 1, 66, 32, 3};
  int run_items [RUNS] = '{260, 200, 120, 200, 150, 100, 200, 120, 200};

  led_matrix_scan_driver_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_cols();
    if (col_reg == 0) return 1;
    if (col_reg > lmsd_pkg::MAX_COLUMNS) return lmsd_pkg::MAX_COLUMNS;
    return 32'(col_reg);
  endfunction

  function automatic int unsigned eff_rows();
    int unsigned r;
    r = 32'(row_reg);
    if (r < 2) r = 2;
    if (r > lmsd_pkg::MAX_ROWS) r = lmsd_pkg::MAX_ROWS;
    return r & ~32'd1;
  endfunction

  task automatic panel_reset();
    col_reg    = 7'd64;
    row_reg    = 6'd32;
    for (int i = 0; i < lmsd_pkg::MAX_ROWS*lmsd_pkg::MAX_COLUMNS; i++) fb_level[i] = '0;
    sc_half    = 0;
    sc_slice   = 0;
    sc_col     = 0;
    sc_phase   = lmsd_pkg::PH_CLK_HIGH;
    hold_addr  = '0;
    hold_blank = 1'b1;
  endtask

  // Advances the mirror by one accepted word and returns the pin word it causes.
  task automatic scan_pin_word(input item_t it, output bit has_word, output pin_word_t w);
    int unsigned cols;
    int unsigned rows;
    int unsigned halves;
    logic [11:0] top;
    logic [11:0] bot;
    cols     = eff_cols();
    rows     = eff_rows();
    halves   = rows / 2;
    w        = '0;
    has_word = 1'b0;
    if (it.op == OP_SET_PIXEL) begin
      if (it.col < cols && it.row < rows)
        fb_level[it.row*lmsd_pkg::MAX_COLUMNS + it.col] =
          {it.red[7:4], it.grn[7:4], it.blu[7:4]};
    end else begin
      has_word = 1'b1;
      // A shrunk size restarts the counters that now lie outside it.
      if (sc_col >= cols) sc_col = 0;
      if (sc_half >= halves) sc_half = 0;
      case (sc_phase) inside
        lmsd_pkg::PH_CLK_HIGH, lmsd_pkg::PH_CLK_LOW: begin
          top     = fb_level[sc_half*lmsd_pkg::MAX_COLUMNS + sc_col];
          bot     = fb_level[(sc_half + halves)*lmsd_pkg::MAX_COLUMNS + sc_col];
          w.sclk  = (sc_phase == lmsd_pkg::PH_CLK_HIGH);
          w.blank = hold_blank;
          w.addr  = hold_addr;
          w.rt    = top[11:8] > sc_slice;
          w.gt    = top[7:4] > sc_slice;
          w.bt    = top[3:0] > sc_slice;
          w.rb    = bot[11:8] > sc_slice;
          w.gb    = bot[7:4] > sc_slice;
          w.bb    = bot[3:0] > sc_slice;
          if (sc_phase == lmsd_pkg::PH_CLK_HIGH) begin
            sc_phase = lmsd_pkg::PH_CLK_LOW;
          end else begin
            sc_col++;
            if (sc_col >= cols) begin
              sc_col   = 0;
              sc_phase = lmsd_pkg::PH_BLANK;
            end else begin
              sc_phase = lmsd_pkg::PH_CLK_HIGH;
            end
          end
        end
        lmsd_pkg::PH_BLANK: begin
          w.blank  = 1'b1;
          w.addr   = hold_addr;
          sc_phase = lmsd_pkg::PH_LATCH;
        end
        lmsd_pkg::PH_LATCH: begin
          w.latch    = 1'b1;
          w.blank    = 1'b1;
          w.addr     = hold_addr;
          hold_blank = 1'b1;
          sc_phase   = lmsd_pkg::PH_UNLATCH;
        end
        lmsd_pkg::PH_UNLATCH: begin
          w.blank  = hold_blank;
          w.addr   = hold_addr;
          sc_phase = lmsd_pkg::PH_ADDRESS;
        end
        lmsd_pkg::PH_ADDRESS: begin
          hold_addr = 4'(sc_half);
          w.blank   = hold_blank;
          w.addr    = hold_addr;
          sc_phase  = lmsd_pkg::PH_ENABLE;
        end
        default: begin
          hold_blank = 1'b0;
          w.addr     = hold_addr;
          sc_phase   = lmsd_pkg::PH_CLK_HIGH;
          sc_col     = 0;
          sc_slice++;
          if (sc_slice >= lmsd_pkg::PWM_SLICES) begin
            sc_slice = 0;
            sc_half++;
            if (sc_half >= halves) begin
              sc_half = 0;
              w.last  = 1'b1;
            end
          end
        end
      endcase
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic pin_word_t ctl_word(logic sclk, logic latch, logic blank, logic [3:0] addr);
    pin_word_t w;
    w       = '0;
    w.sclk  = sclk;
    w.latch = latch;
    w.blank = blank;
    w.addr  = addr;
    return w;
  endfunction

  function automatic step_t tick_row(logic typed, pin_word_t want);
    step_t s;
    s       = '0;
    s.it.op = OP_TICK;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  function automatic step_t pix_row(logic [5:0] col, logic [4:0] row,
                                    logic [7:0] red, logic [7:0] grn, logic [7:0] blu);
    step_t s;
    s        = '0;
    s.it.op  = OP_SET_PIXEL;
    s.it.col = col;
    s.it.row = row;
    s.it.red = red;
    s.it.grn = grn;
    s.it.blu = blu;
    return s;
  endfunction

  function automatic step_t cfg_row(logic [lmsd_pkg::CFG_IDX_W-1:0] idx,
                                    logic [lmsd_pkg::CFG_W-1:0] val);
    step_t s;
    s        = '0;
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.val    = val;
    return s;
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.op = ($urandom_range(0, 3) != 0) ? OP_TICK : OP_SET_PIXEL;
    if ($urandom_range(0, 9) < 7) begin
      it.col = 6'($urandom_range(0, eff_cols() - 1));
      it.row = 5'($urandom_range(0, eff_rows() - 1));
    end else begin
      it.col = 6'($urandom);
      it.row = 5'($urandom);
    end
    it.red = 8'($urandom);
    it.grn = 8'($urandom);
    it.blu = 8'($urandom);
    return it;
  endfunction

  // Offers one word, waits for its handshake and queues the pin word it should cause.
  task automatic feed(input item_t it, input logic typed, input pin_word_t want);
    int        gap;
    bit        has_word;
    pin_word_t w;
    gap = src_calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {5'd0, it.blu, it.grn, it.red, it.row, it.col};
    do @(posedge clk_i); while (!s_axis_tready);
    scan_pin_word(it, has_word, w);
    if (has_word) pin_words_due.push_back(typed ? want : w);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pin_words_due.size() != 0) @(posedge clk_i);
  endtask

  // Registers change only with the block idle; the settling wait lets queued pixel words drain.
  task automatic set_reg(input logic [lmsd_pkg::CFG_IDX_W-1:0] idx,
                         input logic [lmsd_pkg::CFG_W-1:0] val);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == lmsd_pkg::CFG_COLUMN_COUNT) col_reg = val;
    else row_reg = val[5:0];
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pin_words_due.size() == 0) begin
        $error("pin word 0x%h with none expected", m_axis_tdata);
        mismatch_count++;
      end else begin
        got_want = pin_words_due.pop_front();
        check_field("shift_clock", got_want.sclk, m_axis_tdata[0]);
        check_field("latch_strobe", got_want.latch, m_axis_tdata[1]);
        check_field("blank_level", got_want.blank, m_axis_tdata[2]);
        check_field("row_address", got_want.addr, m_axis_tdata[6:3]);
        check_field("red_top", got_want.rt, m_axis_tdata[7]);
        check_field("green_top", got_want.gt, m_axis_tdata[8]);
        check_field("blue_top", got_want.bt, m_axis_tdata[9]);
        check_field("red_bottom", got_want.rb, m_axis_tdata[10]);
        check_field("green_bottom", got_want.gb, m_axis_tdata[11]);
        check_field("blue_bottom", got_want.bb, m_axis_tdata[12]);
        check_field("zero_fill", 0, m_axis_tdata[15:13]);
        check_field("frame_done", got_want.last, m_axis_tlast);
      end
    end
  end

  // Output side: random stalls, quiet stretches, and one long hold on request.
  initial begin
    int stall;
    int calm;
    stall         = 0;
    calm          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        stall         = SINK_HOLD;
      end else if (stall == 0 && calm == 0) begin
        if ($urandom_range(0, 299) == 0) calm = 150;
        else if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
      if (calm > 0) calm--;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("led_matrix_scan_driver_top test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    item_t it;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    mismatch_count = 0;
    stuck_cycles   = 0;
    sink_hold_req  = 1'b0;
    src_calm       = 1'b0;
    panel_reset();

    // Reset state first, then pixels at the corners, clamped and shrunk sizes,
    // ignored pixels and one full slice of control words.
    dir_table.push_back(tick_row(1'b1, ctl_word(1'b1, 1'b0, 1'b1, 4'd0)));
    dir_table.push_back(tick_row(1'b1, ctl_word(1'b0, 1'b0, 1'b1, 4'd0)));
    dir_table.push_back(pix_row(6'd0, 5'd0, 8'hFF, 8'hFF, 8'hFF));
    dir_table.push_back(pix_row(6'd63, 5'd31, 8'hFF, 8'hFF, 8'hFF));
    dir_table.push_back(pix_row(6'd63, 5'd16, 8'h10, 8'h80, 8'hF0));
    dir_table.push_back(tick_row(1'b0, '0));
    dir_table.push_back(cfg_row(lmsd_pkg::CFG_COLUMN_COUNT, 7'd0));
    dir_table.push_back(cfg_row(lmsd_pkg::CFG_ROW_COUNT, 7'd1));
    dir_table.push_back(pix_row(6'd0, 5'd1, 8'h10, 8'h80, 8'hF0));
    dir_table.push_back(pix_row(6'd1, 5'd0, 8'hFF, 8'h00, 8'hFF));
    dir_table.push_back(pix_row(6'd0, 5'd2, 8'h00, 8'hFF, 8'h00));
    dir_table.push_back(pix_row(6'd63, 5'd31, 8'h00, 8'h00, 8'h00));
    dir_table.push_back(pix_row(6'd0, 5'd0, 8'hFF, 8'h2F, 8'h0F));
    dir_table.push_back(tick_row(1'b0, '0));
    dir_table.push_back(tick_row(1'b1, ctl_word(1'b0, 1'b0, 1'b1, 4'd0)));
    dir_table.push_back(tick_row(1'b1, ctl_word(1'b0, 1'b1, 1'b1, 4'd0)));
    dir_table.push_back(tick_row(1'b1, ctl_word(1'b0, 1'b0, 1'b1, 4'd0)));
    dir_table.push_back(tick_row(1'b1, ctl_word(1'b0, 1'b0, 1'b1, 4'd0)));
    dir_table.push_back(tick_row(1'b1, ctl_word(1'b0, 1'b0, 1'b0, 4'd0)));
    dir_table.push_back(tick_row(1'b0, '0));
    dir_table.push_back(tick_row(1'b0, '0));
    dir_table.push_back(cfg_row(lmsd_pkg::CFG_COLUMN_COUNT, 7'd127));
    dir_table.push_back(cfg_row(lmsd_pkg::CFG_ROW_COUNT, 7'd63));
    dir_table.push_back(tick_row(1'b0, '0));
    dir_table.push_back(tick_row(1'b0, '0));
    dir_table.push_back(tick_row(1'b0, '0));

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) set_reg(dir_table[i].idx, dir_table[i].val);
      else feed(dir_table[i].it, dir_table[i].typed, dir_table[i].want);
    end

    for (int p = 0; p < RUNS; p++) begin
      set_reg(lmsd_pkg::CFG_COLUMN_COUNT, 7'(run_cols[p]));
      set_reg(lmsd_pkg::CFG_ROW_COUNT, 7'(run_rows[p]));
      src_calm = (p % 3 == 2);
      for (int n = 0; n < run_items[p]; n++) begin
        // The source keeps offering while the sink holds, so the block backs up.
        if (p == 3 && n == 40) sink_hold_req = 1'b1;
        it = random_item();
        feed(it, 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("led_matrix_scan_driver_top test passed");
    end else begin
      $display("led_matrix_scan_driver_top test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/lmsd_pkg.sv
hdl/lmsd_front.sv
hdl/lmsd_fifo.sv
hdl/lmsd_back.sv
hdl/led_matrix_scan_driver_top.sv
sim/tb_led_matrix_scan_driver_top.sv
